FILE: sv/assert_macros.svh
// Assertion helpers used by numeric_literal_parser.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define NLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define NLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/nlp_pkg.sv
package nlp_pkg;

  localparam int CHAR_W            = 21;
  localparam int IN_TDATA_W        = 24;
  localparam int ACC_WIDTH_DEFAULT = 64;
  localparam int COUNT_WIDTH_DEFAULT = 8;

  localparam logic [CHAR_W-1:0] CH_PLUS   = 21'h00002B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 21'h00002D;
  localparam logic [CHAR_W-1:0] CH_POINT  = 21'h00002E;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 21'h000030;
  localparam logic [CHAR_W-1:0] CH_ONE    = 21'h000031;
  localparam logic [CHAR_W-1:0] CH_NINE   = 21'h000039;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 21'h000041;
  localparam logic [CHAR_W-1:0] CH_UP_B   = 21'h000042;
  localparam logic [CHAR_W-1:0] CH_UP_F   = 21'h000046;
  localparam logic [CHAR_W-1:0] CH_UP_X   = 21'h000058;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 21'h000061;
  localparam logic [CHAR_W-1:0] CH_LO_B   = 21'h000062;
  localparam logic [CHAR_W-1:0] CH_LO_E   = 21'h000065;
  localparam logic [CHAR_W-1:0] CH_LO_F   = 21'h000066;
  localparam logic [CHAR_W-1:0] CH_LO_X   = 21'h000078;

  // Letters a-f and A-F share their low nibble offset: value = nibble + 9.
  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

  typedef enum logic [4:0] {
    SEC_DEC  = 5'b00001,
    SEC_FRAC = 5'b00010,
    SEC_EXP  = 5'b00100,
    SEC_HEX  = 5'b01000,
    SEC_BIN  = 5'b10000
  } section_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_POINT   = 2'd1,
    ERR_EXPMARK = 2'd2,
    ERR_CHAR    = 2'd3
  } err_t;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_BIN = 2'd2;

  typedef struct packed {
    logic       plus;
    logic       minus;
    logic       zero;
    logic       xmark;
    logic       bmark;
    logic       point;
    logic       emark;
    logic       dec_digit;
    logic       bin_digit;
    logic       hex_letter;
    logic [3:0] value;
  } char_class_t;

endpackage

FILE: sv/nlp_classify.sv
module nlp_classify (
  input  logic [nlp_pkg::CHAR_W-1:0] character,
  output nlp_pkg::char_class_t       cls
);
  import nlp_pkg::*;

  logic lo_hex;
  logic up_hex;

  always_comb begin
    lo_hex         = (character >= CH_LO_A) && (character <= CH_LO_F);
    up_hex         = (character >= CH_UP_A) && (character <= CH_UP_F);
    cls.plus       = (character == CH_PLUS);
    cls.minus      = (character == CH_MINUS);
    cls.zero       = (character == CH_ZERO);
    cls.xmark      = (character == CH_LO_X) || (character == CH_UP_X);
    cls.bmark      = (character == CH_LO_B) || (character == CH_UP_B);
    cls.point      = (character == CH_POINT);
    cls.emark      = (character == CH_LO_E);
    cls.dec_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
    cls.bin_digit  = (character == CH_ZERO) || (character == CH_ONE);
    cls.hex_letter = lo_hex || up_hex;
    if (lo_hex || up_hex) begin
      cls.value = character[3:0] + HEX_LETTER_OFS;
    end else begin
      cls.value = character[3:0];
    end
  end

endmodule

FILE: sv/nlp_core.sv
module nlp_core #(
  parameter int ACC_WIDTH   = nlp_pkg::ACC_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH = nlp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   last,
  input  nlp_pkg::char_class_t   cls,
  output logic                   res_negative,
  output logic [1:0]             res_radix,
  output logic [ACC_WIDTH-1:0]   res_integer,
  output logic [ACC_WIDTH-1:0]   res_fraction,
  output logic [COUNT_WIDTH-1:0] res_count,
  output logic [ACC_WIDTH-1:0]   res_exponent,
  output logic [1:0]             res_error
);
  import nlp_pkg::*;

  logic [1:0]             pos_r, pos_nxt;
  logic                   fwz_r, fwz_nxt;
  section_t               sec_r, sec_nxt;
  logic                   sign_r, sign_nxt;
  logic [ACC_WIDTH-1:0]   int_r, int_nxt;
  logic [ACC_WIDTH-1:0]   frac_r, frac_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [ACC_WIDTH-1:0]   exp_r, exp_nxt;
  err_t                   err_r, err_nxt;

  logic [ACC_WIDTH-1:0]   mac_src;
  logic [ACC_WIDTH-1:0]   mac10;
  logic [ACC_WIDTH-1:0]   digit_ext;
  logic                   digit_ok;

  // One times-ten multiply-add serves the decimal integer, fraction and exponent.
  always_comb begin
    digit_ext = ACC_WIDTH'(cls.value);
    case (sec_r)
      SEC_FRAC: mac_src = frac_r;
      SEC_EXP:  mac_src = exp_r;
      default:  mac_src = int_r;
    endcase
    mac10 = (mac_src << 3) + (mac_src << 1) + digit_ext;
    case (sec_r)
      SEC_BIN: digit_ok = cls.bin_digit;
      SEC_HEX: digit_ok = cls.dec_digit || cls.hex_letter;
      default: digit_ok = cls.dec_digit;
    endcase
  end

  always_comb begin
    pos_nxt  = (pos_r == 2'd2) ? pos_r : pos_r + 2'd1;
    fwz_nxt  = fwz_r;
    sec_nxt  = sec_r;
    sign_nxt = sign_r;
    int_nxt  = int_r;
    frac_nxt = frac_r;
    cnt_nxt  = cnt_r;
    exp_nxt  = exp_r;
    err_nxt  = err_r;
    // Once an error is latched, characters only advance the position.
    if (err_r == ERR_NONE) begin
      if ((pos_r == 2'd0) && cls.zero) begin
        fwz_nxt = 1'b1;
      end
      if ((pos_r == 2'd0) && cls.plus) begin
        sign_nxt = sign_r;
      end else if ((pos_r == 2'd0) && cls.minus) begin
        sign_nxt = 1'b1;
      end else if ((pos_r == 2'd1) && fwz_r && cls.xmark) begin
        sec_nxt = SEC_HEX;
      end else if ((pos_r == 2'd1) && fwz_r && cls.bmark) begin
        sec_nxt = SEC_BIN;
      end else if (cls.point) begin
        if (sec_r == SEC_DEC) begin
          sec_nxt = SEC_FRAC;
        end else begin
          err_nxt = ERR_POINT;
        end
      end else if (cls.emark && (sec_r != SEC_HEX)) begin
        if ((sec_r == SEC_DEC) || (sec_r == SEC_FRAC)) begin
          sec_nxt = SEC_EXP;
        end else begin
          err_nxt = ERR_EXPMARK;
        end
      end else if (!digit_ok) begin
        err_nxt = ERR_CHAR;
      end else begin
        case (sec_r)
          SEC_HEX: int_nxt = {int_r[ACC_WIDTH-5:0], cls.value};
          SEC_BIN: int_nxt = {int_r[ACC_WIDTH-2:0], cls.value[0]};
          SEC_FRAC: begin
            frac_nxt = mac10;
            if (cnt_r != {COUNT_WIDTH{1'b1}}) begin
              cnt_nxt = cnt_r + COUNT_WIDTH'(1);
            end
          end
          SEC_EXP: exp_nxt = mac10;
          default: int_nxt = mac10;
        endcase
      end
    end
  end

  always_comb begin
    res_negative = sign_nxt;
    case (sec_nxt)
      SEC_HEX: res_radix = RADIX_HEX;
      SEC_BIN: res_radix = RADIX_BIN;
      default: res_radix = RADIX_DEC;
    endcase
    res_integer  = int_nxt;
    res_fraction = frac_nxt;
    res_count    = cnt_nxt;
    res_exponent = exp_nxt;
    res_error    = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      pos_r  <= 2'd0;
      fwz_r  <= 1'b0;
      sec_r  <= SEC_DEC;
      sign_r <= 1'b0;
      int_r  <= '0;
      frac_r <= '0;
      cnt_r  <= '0;
      exp_r  <= '0;
      err_r  <= ERR_NONE;
    end else if (step) begin
      pos_r  <= pos_nxt;
      fwz_r  <= fwz_nxt;
      sec_r  <= sec_nxt;
      sign_r <= sign_nxt;
      int_r  <= int_nxt;
      frac_r <= frac_nxt;
      cnt_r  <= cnt_nxt;
      exp_r  <= exp_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

FILE: sv/numeric_literal_parser.sv
// Numeric literal parser.
// Input channel (in_*): one code point per transaction in in_tdata[20:0]; in_tlast
// marks the final character of a literal. Signs, 0x/0b prefixes, decimal digits,
// a fraction after '.', and an unsigned exponent after 'e' are recognized.
// Result channel (out_*): one transaction per literal, issued for the character
// that carries in_tlast. Fields are packed in out_tdata as listed at the port.
// The result is valid in the cycle after the last character is accepted.
// Throughput: one character per cycle while in_tready is high; the per-character
// path is a single times-ten multiply-add over the state registers.
// The result sits in a one-entry output register. While it waits, in_tready stays
// high as long as out_tready is high; when the receiver stalls with a result held,
// in_tready drops and no character is taken until that result leaves.
// Reset clears the parse state to an empty literal and empties the output register.
// Every last character returns the parse state to that same empty condition.
`include "assert_macros.svh"

module numeric_literal_parser #(
  parameter int ACC_WIDTH   = nlp_pkg::ACC_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH = nlp_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // character (21 bits), zero padded
  input  logic [nlp_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // negative, radix, integer_part, fraction_value, fraction_digits,
  // exponent_value, error_code, zero padded
  output logic [((3*ACC_WIDTH+COUNT_WIDTH+5+7)/8)*8-1:0] out_tdata
);
  import nlp_pkg::*;

  localparam int OUT_BITS    = 3*ACC_WIDTH + COUNT_WIDTH + 5;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  char_class_t            cls;
  logic                   in_fire;
  logic                   res_negative;
  logic [1:0]             res_radix;
  logic [ACC_WIDTH-1:0]   res_integer;
  logic [ACC_WIDTH-1:0]   res_fraction;
  logic [COUNT_WIDTH-1:0] res_count;
  logic [ACC_WIDTH-1:0]   res_exponent;
  logic [1:0]             res_error;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  nlp_classify u_classify (
    .character (in_tdata[CHAR_W-1:0]),
    .cls       (cls)
  );

  nlp_core #(
    .ACC_WIDTH   (ACC_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_fire),
    .last         (in_tlast),
    .cls          (cls),
    .res_negative (res_negative),
    .res_radix    (res_radix),
    .res_integer  (res_integer),
    .res_fraction (res_fraction),
    .res_count    (res_count),
    .res_exponent (res_exponent),
    .res_error    (res_error)
  );

  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    if (in_fire && in_tlast) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = OUT_TDATA_W'({res_error, res_exponent, res_count, res_fraction,
                                     res_integer, res_radix, res_negative});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `NLP_ASSERT(a_result_follows_last, (in_fire && in_tlast) |=> out_tvalid_r, "result lost after last character")
  `NLP_ASSERT(a_result_from_last, $rose(out_tvalid_r) |-> $past(in_fire && in_tlast), "result without last character")
  `NLP_ASSERT(a_radix_code, out_tvalid_r |-> (out_tdata_r[2:1] != 2'd3), "undefined radix code")
  `NLP_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> !out_tvalid_r, "output valid right after reset")

endmodule

FILE: test/nlp_checker.sv
`timescale 1ns / 100ps

module nlp_checker #(
  parameter int OUT_W = 208
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // character (21 bits), zero padded
  input  logic [nlp_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           in_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // negative, radix, integer_part, fraction_value, fraction_digits,
  // exponent_value, error_code, zero padded
  input  logic [OUT_W-1:0]               out_tdata,
  output int                             failures,
  output int                             pending
);
  import nlp_pkg::*;

  typedef struct packed {
    logic        negative;
    logic [1:0]  radix;
    logic [63:0] integer_part;
    logic [63:0] fraction_value;
    logic [7:0]  fraction_digits;
    logic [63:0] exponent_value;
    logic [1:0]  error_code;
  } literal_result_t;

  // Parse state of the literal currently being received.
  logic [1:0]  char_pos;
  logic        lead_zero;
  section_t    sec;
  logic        minus_seen;
  logic [63:0] int_acc;
  logic [63:0] frac_acc;
  logic [7:0]  frac_cnt;
  logic [63:0] exp_acc;
  err_t        parse_err;

  literal_result_t expected_literals[$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  task automatic clear_literal();
    char_pos   = 2'd0;
    lead_zero  = 1'b0;
    sec        = SEC_DEC;
    minus_seen = 1'b0;
    int_acc    = '0;
    frac_acc   = '0;
    frac_cnt   = '0;
    exp_acc    = '0;
    parse_err  = ERR_NONE;
  endtask

  // Returns the digit value of ch in the given section, or -1.
  function automatic int digit_of(input logic [CHAR_W-1:0] ch, input section_t s);
    if (s == SEC_BIN)
      return (ch == CH_ZERO || ch == CH_ONE) ? int'(ch - CH_ZERO) : -1;
    if (ch >= CH_ZERO && ch <= CH_NINE)
      return int'(ch - CH_ZERO);
    if (s == SEC_HEX) begin
      if (ch >= CH_LO_A && ch <= CH_LO_F)
        return int'(ch - CH_LO_A) + 10;
      if (ch >= CH_UP_A && ch <= CH_UP_F)
        return int'(ch - CH_UP_A) + 10;
    end
    return -1;
  endfunction

  task automatic scan_char(input logic [CHAR_W-1:0] ch);
    logic [1:0] pos;
    int         d;
    pos = char_pos;
    if (char_pos < 2'd2)
      char_pos = char_pos + 2'd1;
    // Once an error is flagged, the rest of the literal is ignored.
    if (parse_err != ERR_NONE)
      return;
    if (pos == 2'd0) begin
      if (ch == CH_ZERO)
        lead_zero = 1'b1;
      if (ch == CH_PLUS)
        return;
      if (ch == CH_MINUS) begin
        minus_seen = 1'b1;
        return;
      end
    end
    if (pos == 2'd1 && lead_zero) begin
      if (ch == CH_LO_X || ch == CH_UP_X) begin
        sec = SEC_HEX;
        return;
      end
      if (ch == CH_LO_B || ch == CH_UP_B) begin
        sec = SEC_BIN;
        return;
      end
    end
    if (ch == CH_POINT) begin
      if (sec == SEC_DEC)
        sec = SEC_FRAC;
      else
        parse_err = ERR_POINT;
      return;
    end
    // In hexadecimal the letter e is a digit, not an exponent mark.
    if (ch == CH_LO_E && sec != SEC_HEX) begin
      if (sec == SEC_DEC || sec == SEC_FRAC)
        sec = SEC_EXP;
      else
        parse_err = ERR_EXPMARK;
      return;
    end
    d = digit_of(ch, sec);
    if (d < 0) begin
      parse_err = ERR_CHAR;
      return;
    end
    case (sec)
      SEC_DEC:  int_acc = int_acc * 64'd10 + 64'(d);
      SEC_HEX:  int_acc = int_acc * 64'd16 + 64'(d);
      SEC_BIN:  int_acc = int_acc * 64'd2 + 64'(d);
      SEC_FRAC: begin
        frac_acc = frac_acc * 64'd10 + 64'(d);
        if (frac_cnt != 8'hFF)
          frac_cnt = frac_cnt + 8'd1;
      end
      default:  exp_acc = exp_acc * 64'd10 + 64'(d);
    endcase
  endtask

  function automatic literal_result_t parsed_literal();
    literal_result_t r;
    r.negative        = minus_seen;
    r.radix           = (sec == SEC_HEX) ? RADIX_HEX : (sec == SEC_BIN) ? RADIX_BIN : RADIX_DEC;
    r.integer_part    = int_acc;
    r.fraction_value  = frac_acc;
    r.fraction_digits = frac_cnt;
    r.exponent_value  = exp_acc;
    r.error_code      = parse_err;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    literal_result_t want;
    literal_result_t got;
    if (!rst_n) begin
      clear_literal();
      expected_literals.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.negative        = out_tdata[0];
        got.radix           = out_tdata[2:1];
        got.integer_part    = out_tdata[66:3];
        got.fraction_value  = out_tdata[130:67];
        got.fraction_digits = out_tdata[138:131];
        got.exponent_value  = out_tdata[202:139];
        got.error_code      = out_tdata[204:203];
        if (expected_literals.size() == 0) begin
          $error("result transaction with no literal outstanding");
          failures++;
        end else begin
          want = expected_literals.pop_front();
          check_field("negative", 64'(want.negative), 64'(got.negative));
          check_field("radix", 64'(want.radix), 64'(got.radix));
          check_field("integer_part", want.integer_part, got.integer_part);
          check_field("fraction_value", want.fraction_value, got.fraction_value);
          check_field("fraction_digits", 64'(want.fraction_digits),
                      64'(got.fraction_digits));
          check_field("exponent_value", want.exponent_value, got.exponent_value);
          check_field("error_code", 64'(want.error_code), 64'(got.error_code));
        end
      end
      if (in_tvalid && in_tready) begin
        scan_char(in_tdata[CHAR_W-1:0]);
        if (in_tlast) begin
          expected_literals.push_back(parsed_literal());
          clear_literal();
        end
      end
    end
    pending = expected_literals.size();
  end

endmodule

FILE: test/tb_numeric_literal_parser.sv
`timescale 1ns / 100ps

module tb_numeric_literal_parser;
  import nlp_pkg::*;

  localparam int OUT_W =
    ((3*ACC_WIDTH_DEFAULT + COUNT_WIDTH_DEFAULT + 5 + 7) / 8) * 8;
  localparam int RANDOM_CHARS = 1900;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  int                    failures;
  int                    pending;

  int                    chars_sent;
  int                    burst_left;
  logic                  steady;
  logic                  long_fraction;
  logic [CHAR_W-1:0]     literal_chars[$];

  int                    stall_phase;
  logic [1:0]            stall_mode;

  numeric_literal_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  nlp_checker #(.OUT_W(OUT_W)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .failures   (failures),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  // The receiver switches between always ready, random stalls and periodic stall patterns.
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  = 2'($urandom_range(0, 3));
      stall_phase = $urandom_range(16, 96);
    end else begin
      stall_phase = stall_phase - 1;
    end
    case (stall_mode)
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= 1'($urandom_range(0, 1));
      2'd2:    out_tready <= (stall_phase[2:0] != 3'd0);
      default: out_tready <= stall_phase[3];
    endcase
  end

  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic lst);
    int gap;
    gap = 0;
    if (chars_sent % 200 == 0)
      steady = ($urandom_range(0, 2) == 0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 5);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-CHAR_W){1'b0}}, ch};
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left = burst_left - 1;
    chars_sent = chars_sent + 1;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(CHAR_W'(s[i]), i == s.len() - 1);
  endtask

  function automatic logic [CHAR_W-1:0] noise_char();
    string pool;
    pool = "+-.xXbBeE0123456789aAfFgGzZ_ ";
    if ($urandom_range(0, 1))
      return CHAR_W'(pool[$urandom_range(0, pool.len() - 1)]);
    return CHAR_W'($urandom_range(0, 1114111));
  endfunction

  function automatic int digit_count();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(17, 24);
    return $urandom_range(0, 6);
  endfunction

  task automatic push_digits(input int count, input int base);
    string hex_pool;
    hex_pool = "0123456789abcdefABCDEF";
    repeat (count) begin
      case (base)
        16:      literal_chars.push_back(
                   CHAR_W'(hex_pool[$urandom_range(0, hex_pool.len() - 1)]));
        2:       literal_chars.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 1)));
        default: literal_chars.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
      endcase
    end
  endtask

  // Mostly well-formed literals with random content; the rest are
  // corrupted literals and plain noise.
  task automatic compose_literal();
    int   roll;
    int   form;
    logic corrupt;
    literal_chars.delete();
    roll = $urandom_range(0, 99);
    if (roll >= 90) begin
      repeat ($urandom_range(1, 6)) literal_chars.push_back(noise_char());
      return;
    end
    corrupt = (roll >= 80);
    form = $urandom_range(0, 5);
    if (form <= 2) begin
      if ($urandom_range(0, 3) == 0)
        literal_chars.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      push_digits(digit_count(), 10);
      if (long_fraction || $urandom_range(0, 1)) begin
        literal_chars.push_back(CH_POINT);
        push_digits(long_fraction ? $urandom_range(256, 290) : digit_count(), 10);
      end
      if ($urandom_range(0, 4) < 2) begin
        literal_chars.push_back(CH_LO_E);
        push_digits(digit_count(), 10);
      end
      long_fraction = 1'b0;
    end else begin
      if ($urandom_range(0, 9) == 0)
        literal_chars.push_back(CH_MINUS);
      literal_chars.push_back(CH_ZERO);
      if (form <= 4) begin
        literal_chars.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
        push_digits($urandom_range(0, 18), 16);
      end else begin
        literal_chars.push_back($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
        push_digits($urandom_range(0, 70), 2);
      end
    end
    if (literal_chars.size() == 0)
      push_digits(1, 10);
    if (corrupt)
      literal_chars[$urandom_range(0, literal_chars.size() - 1)] = noise_char();
  endtask

  initial begin
    int literal_index;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    out_tready    = 1'b0;
    stall_phase   = 0;
    stall_mode    = 2'd0;
    chars_sent    = 0;
    burst_left    = 0;
    steady        = 1'b0;
    long_fraction = 1'b0;
    literal_index = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sign, fraction and exponent; hex prefix with e as a digit; e in binary;
    // point in hex; uppercase E and the sticky error after it; a prefix after
    // a sign; a lone sign; the highest and lowest code points.
    send_text("-1.5e3");
    send_text("0xeF");
    send_text("0b1e");
    send_text("0X.");
    send_text("1E5");
    send_text("-0x1");
    send_text("+");
    send_char(21'h10FFFF, 1'b1);
    send_char(21'h000000, 1'b1);

    while (chars_sent < RANDOM_CHARS) begin
      // A long fraction request stays pending until a decimal literal takes it.
      if (literal_index == 4 || literal_index == 120)
        long_fraction = 1'b1;
      compose_literal();
      foreach (literal_chars[i])
        send_char(literal_chars[i], i == literal_chars.size() - 1);
      literal_index++;
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/nlp_pkg.sv
sv/nlp_classify.sv
sv/nlp_core.sv
sv/numeric_literal_parser.sv
test/nlp_checker.sv
test/tb_numeric_literal_parser.sv
